>>> rtl/mau_pkg.sv
// Shared types and constants of the modular arithmetic unit.
package mau_pkg;

  localparam int unsigned ResW  = 31;
  localparam int unsigned OpAW  = 32;
  localparam int unsigned FuncW = 4;
  localparam int unsigned StW   = 2;

  typedef enum logic [FuncW-1:0] {
    FN_REDUCE = 4'd0,
    FN_ADD    = 4'd1,
    FN_SUB    = 4'd2,
    FN_NEG    = 4'd3,
    FN_MUL    = 4'd4,
    FN_INV    = 4'd5,
    FN_DIV    = 4'd6,
    FN_DVTEST = 4'd7,
    FN_UNIT   = 4'd8
  } func_t;

  typedef enum logic [StW-1:0] {
    ST_OK       = 2'd0,
    ST_NOT_UNIT = 2'd1,
    ST_NO_SOLVE = 2'd2
  } status_t;

endpackage

>>> rtl/mau_if.sv
// Request, response and modulus write channels of the modular arithmetic unit.
interface mau_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [mau_pkg::FuncW-1:0]             func;
  logic signed [mau_pkg::OpAW-1:0]       operand_a;
  logic [mau_pkg::ResW-1:0]              operand_b;
  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface mau_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mau_pkg::ResW-1:0]     result;
  logic [mau_pkg::StW-1:0]      status;
  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

interface mau_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mau_pkg::ResW-1:0]     modulus;
  modport source (output valid, modulus, input ready);
  modport sink   (input valid, modulus, output ready);
endinterface

>>> rtl/modular_arithmetic_unit_core.sv
// Modular arithmetic unit: one request at a time through a shared bit-serial
// divider and a shared multiplier. Every request first reduces operand_a and
// operand_b by the modulus, two 32-step divisions, which is all the division
// that reduce, add, sub and neg need; mul adds a 64-step reduction of the
// product. Inverse, divide and the two tests run extended Euclid, each round
// being one 32-step division plus a multiply and an update, for up to about
// 45 rounds; divide then adds a 32-step and a 64-step division. A modulus of
// 0 acts as 1. The request channel is ready only while no request is in
// progress; a finished result waits in the response register, and the next
// request can start but not finish until it is taken. The user must write the
// modulus through cfg only while the unit is idle; the unit does not enforce it.
module modular_arithmetic_unit_core #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  mau_req_if.sink   req,
  mau_rsp_if.source rsp,
  mau_cfg_if.sink   cfg
);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_RA   = 15'h0002,
    S_RB   = 15'h0004,
    S_OP   = 15'h0008,
    S_MUL  = 15'h0010,
    S_PDIV = 15'h0020,
    S_RED  = 15'h0040,
    S_EU   = 15'h0080,
    S_EU2  = 15'h0100,
    S_EU3  = 15'h0200,
    S_GDON = 15'h0400,
    S_XDIV = 15'h0800,
    S_YDIV = 15'h1000,
    S_DIV  = 15'h2000,
    S_FIN  = 15'h4000
  } state_t;

  localparam int unsigned RW = mau_pkg::ResW;

  state_t                state, ret;
  logic [RW-1:0]         modulus, q;
  mau_pkg::func_t        func;
  logic                  a_neg;
  logic [RW-1:0]         b, x, y, u, v;
  logic signed [RW+1:0]  cu, cv;
  logic [63:0]           quo;
  logic [RW-1:0]         rem, dvs;
  logic [6:0]            cnt;
  logic signed [64:0]    prod;
  logic [RW-1:0]         res;
  mau_pkg::status_t      st;
  logic                  o_valid;
  logic [RW-1:0]         o_result;
  logic [mau_pkg::StW-1:0] o_status;

  logic [WORD_BITS-1:0]  a_w;
  logic [31:0]           a_sx, a_mag;
  logic [31:0]           r2;
  logic                  ge;
  logic [RW-1:0]         mul_a;
  logic signed [RW+1:0]  mul_b;
  logic [RW:0]           sum_xy;
  logic [RW:0]           dif_xy;
  logic signed [RW+1:0]  cu_fix;

  // Sign-extend operand_a from WORD_BITS and take its magnitude
  assign a_w   = req.operand_a[WORD_BITS-1:0];
  assign a_sx  = 32'($signed(a_w));
  assign a_mag = a_w[WORD_BITS-1] ? (~a_sx + 32'd1) : a_sx;

  assign q = (modulus == '0) ? RW'(1) : modulus;

  // One divider step: shift in the next dividend bit, subtract if it fits
  assign r2 = {rem, quo[63]};
  assign ge = (r2 >= {1'b0, dvs});

  // Shared multiplier operand select
  always_comb begin
    if (state == S_EU2) begin
      mul_a = quo[RW-1:0];
      mul_b = cv;
    end else begin
      mul_a = x;
      mul_b = {2'b00, y};
    end
  end

  assign sum_xy = {1'b0, x} + {1'b0, y};
  assign dif_xy = {1'b0, x} - {1'b0, y};
  assign cu_fix = cu[RW+1] ? (cu + $signed({2'b00, q})) : cu;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = o_valid;
  assign rsp.result = o_result;
  assign rsp.status = o_status;

  // Product register, refreshed every cycle
  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, mul_a}) * mul_b;
  end

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= RW'(1);
    end else if (cfg.valid) begin
      modulus <= cfg.modulus;
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      o_valid <= 1'b0;
      cnt     <= '0;
    end else begin
      // Drop the held response once taken, unless a new one loads now
      if (rsp.ready && state != S_FIN) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            func  <= mau_pkg::func_t'(req.func);
            a_neg <= a_w[WORD_BITS-1];
            b     <= req.operand_b;
            st    <= mau_pkg::ST_OK;
            res   <= '0;
            quo   <= {a_mag, 32'd0};
            rem   <= '0;
            dvs   <= q;
            cnt   <= 7'd32;
            ret   <= S_RA;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= ge ? RW'(r2 - {1'b0, dvs}) : RW'(r2);
          quo <= {quo[62:0], ge};
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            state <= ret;
          end
        end
        S_RA: begin
          x     <= (a_neg && rem != '0) ? (q - rem) : rem;
          quo   <= {1'b0, b, 32'd0};
          rem   <= '0;
          cnt   <= 7'd32;
          ret   <= S_RB;
          state <= S_DIV;
        end
        S_RB: begin
          y     <= rem;
          state <= S_OP;
        end
        S_OP: begin
          state <= S_FIN;
          unique case (func)
            mau_pkg::FN_REDUCE: res <= x;
            mau_pkg::FN_ADD:
              res <= (sum_xy >= {1'b0, q}) ? RW'(sum_xy - {1'b0, q}) : RW'(sum_xy);
            mau_pkg::FN_SUB:
              res <= dif_xy[RW] ? RW'(dif_xy + {1'b0, q}) : RW'(dif_xy);
            mau_pkg::FN_NEG: res <= (x == '0) ? '0 : (q - x);
            mau_pkg::FN_MUL: state <= S_MUL;
            mau_pkg::FN_DIV: begin
              u     <= y;
              v     <= q;
              cu    <= (RW+2)'(1);
              cv    <= '0;
              state <= S_EU;
            end
            mau_pkg::FN_INV, mau_pkg::FN_DVTEST, mau_pkg::FN_UNIT: begin
              u     <= q;
              v     <= x;
              cu    <= '0;
              cv    <= (RW+2)'(1);
              state <= S_EU;
            end
            default: res <= '0;
          endcase
        end
        S_MUL: begin
          state <= S_PDIV;
        end
        S_PDIV: begin
          quo   <= {2'b00, prod[61:0]};
          rem   <= '0;
          dvs   <= q;
          cnt   <= 7'd64;
          ret   <= S_RED;
          state <= S_DIV;
        end
        S_RED: begin
          res   <= rem;
          state <= S_FIN;
        end
        // Euclid round: divide u by v, then update the coefficient
        S_EU: begin
          if (v == '0) begin
            state <= S_GDON;
          end else begin
            quo   <= {1'b0, u, 32'd0};
            rem   <= '0;
            dvs   <= v;
            cnt   <= 7'd32;
            ret   <= S_EU2;
            state <= S_DIV;
          end
        end
        S_EU2: begin
          u     <= v;
          v     <= rem;
          state <= S_EU3;
        end
        S_EU3: begin
          cv    <= cu - prod[RW+1:0];
          cu    <= cv;
          state <= S_EU;
        end
        S_GDON: begin
          state <= S_FIN;
          unique case (func)
            mau_pkg::FN_INV: begin
              if (u != RW'(1) || x == '0) begin
                st  <= mau_pkg::ST_NOT_UNIT;
                res <= '0;
              end else begin
                res <= cu_fix[RW-1:0];
              end
            end
            mau_pkg::FN_UNIT: res <= (u == RW'(1)) ? RW'(1) : '0;
            mau_pkg::FN_DVTEST: begin
              quo   <= {1'b0, y, 32'd0};
              rem   <= '0;
              dvs   <= u;
              cnt   <= 7'd32;
              ret   <= S_YDIV;
              state <= S_DIV;
            end
            default: begin
              quo   <= {1'b0, x, 32'd0};
              rem   <= '0;
              dvs   <= u;
              cnt   <= 7'd32;
              ret   <= S_XDIV;
              state <= S_DIV;
            end
          endcase
        end
        S_YDIV: begin
          res   <= (rem == '0) ? RW'(1) : '0;
          state <= S_FIN;
        end
        // Solvable when gcd divides x: multiply coefficient by x / gcd
        S_XDIV: begin
          if (rem != '0) begin
            st    <= mau_pkg::ST_NO_SOLVE;
            res   <= '0;
            state <= S_FIN;
          end else begin
            x     <= cu_fix[RW-1:0];
            y     <= quo[RW-1:0];
            state <= S_MUL;
          end
        end
        S_FIN: begin
          if (!o_valid || rsp.ready) begin
            o_valid  <= 1'b1;
            o_result <= res;
            o_status <= st;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
